[rtl/core/kca_pkg.sv]
// ---------------------------------------------------------------------------
// kca_pkg - shared types and constants for the key colour alpha generator
// Grey weights, register indexes, alpha rule codes and pipeline structs.
// ---------------------------------------------------------------------------
package kca_pkg;

  localparam int unsigned CH_W   = 8;   // one colour byte
  localparam int unsigned PROD_W = 16;  // byte times weight, below 255*256
  localparam int unsigned IDX_W  = 8;   // configuration register index

  localparam logic [7:0] W_RED   = 8'd76;
  localparam logic [7:0] W_GREEN = 8'd150;
  localparam logic [7:0] W_BLUE  = 8'd28;
  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'h00;

  // Register map
  localparam logic [IDX_W-1:0] REG_KEY_RED   = 8'd0;
  localparam logic [IDX_W-1:0] REG_KEY_GREEN = 8'd1;
  localparam logic [IDX_W-1:0] REG_KEY_BLUE  = 8'd2;
  localparam logic [IDX_W-1:0] REG_ALPHA_MODE = 8'd3;

  // Alpha rule codes; code 7 is unused and treated as opaque
  localparam logic [2:0] MODE_OPAQUE = 3'd0;
  localparam logic [2:0] MODE_GREY   = 3'd1;
  localparam logic [2:0] MODE_KEY_EQ = 3'd2;
  localparam logic [2:0] MODE_KEY_GE = 3'd3;
  localparam logic [2:0] MODE_KEY_LE = 3'd4;
  localparam logic [2:0] MODE_KEY_GT = 3'd5;
  localparam logic [2:0] MODE_KEY_LT = 3'd6;

  // Per-stage load enables into the grey unit
  typedef struct packed {
    logic ld_mul;
    logic ld_div;
    logic ld_sum;
  } grey_en_t;

  // Word data carried beside the grey arithmetic
  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    logic [2:0]      mode;
    logic            key_eq;
  } side_t;

  // floor(x / 255) for x below 65280: (x + (x >> 8) + 1) >> 8
  function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] t;
    t = {1'b0, x} + {9'd0, x[PROD_W-1:8]} + 17'd1;
    return t[PROD_W-1:8];
  endfunction

endpackage

[rtl/core/kca_grey.sv]
// ---------------------------------------------------------------------------
// kca_grey - three stage weighted grey value
// Weights each byte, scales each product by 1/255, then sums (max 254).
// ---------------------------------------------------------------------------
module kca_grey
  import kca_pkg::*;
(
  input  logic            clk,
  input  grey_en_t        en,
  input  logic [CH_W-1:0] red,
  input  logic [CH_W-1:0] green,
  input  logic [CH_W-1:0] blue,
  output logic [CH_W-1:0] grey
);

  logic [PROD_W-1:0] pr_r, pg_r, pb_r;
  logic [CH_W-1:0]   qr_r, qg_r, qb_r;
  logic [CH_W-1:0]   grey_r;
  logic [CH_W+1:0]   sum;

  always_ff @(posedge clk) begin
    if (en.ld_mul) begin
      pr_r <= PROD_W'(red * W_RED);
      pg_r <= PROD_W'(green * W_GREEN);
      pb_r <= PROD_W'(blue * W_BLUE);
    end
    if (en.ld_div) begin
      qr_r <= div255(pr_r);
      qg_r <= div255(pg_r);
      qb_r <= div255(pb_r);
    end
    if (en.ld_sum) begin
      grey_r <= sum[CH_W-1:0];
    end
  end

  // terms are at most 76, 150 and 28, so the sum fits a byte
  assign sum  = {2'b00, qr_r} + {2'b00, qg_r} + {2'b00, qb_r};
  assign grey = grey_r;

endmodule

[rtl/core/kca_alpha.sv]
// ---------------------------------------------------------------------------
// kca_alpha - alpha rule select
// Picks alpha from the pixel grey, key grey and key match per mode.
// ---------------------------------------------------------------------------
module kca_alpha
  import kca_pkg::*;
(
  input  logic [2:0]      mode,
  input  logic            key_eq,
  input  logic [CH_W-1:0] pix_grey,
  input  logic [CH_W-1:0] key_grey,
  output logic [CH_W-1:0] alpha
);

  always_comb begin
    case (mode)
      MODE_GREY:   alpha = pix_grey;
      MODE_KEY_EQ: alpha = key_eq ? ALPHA_CLEAR : ALPHA_OPAQUE;
      MODE_KEY_GE: alpha = (key_grey >= pix_grey) ? ALPHA_CLEAR : ALPHA_OPAQUE;
      MODE_KEY_LE: alpha = (key_grey <= pix_grey) ? ALPHA_CLEAR : ALPHA_OPAQUE;
      MODE_KEY_GT: alpha = (key_grey >  pix_grey) ? ALPHA_CLEAR : ALPHA_OPAQUE;
      MODE_KEY_LT: alpha = (key_grey <  pix_grey) ? ALPHA_CLEAR : ALPHA_OPAQUE;
      default:     alpha = ALPHA_OPAQUE;
    endcase
  end

endmodule

[rtl/core/key_colour_alpha_generator.sv]
// ---------------------------------------------------------------------------
// key_colour_alpha_generator - adds an alpha byte to a BGR pixel stream
// In: one BGR pixel per word. Out: the same BGR bytes plus alpha.
// Config: four registers (key red, green, blue, alpha mode) written over
// cfg_*; always ready. Write only while no pixel is in flight.
// Pipeline: four register stages (weight multiply, 1/255 scale, grey sum,
// alpha select into the output register); out_tvalid rises when a word
// reaches the output register. Throughput: one word per clock while
// out_tready is high. Every stage has its own valid bit and loads when it
// is empty or its successor moves, so bubbles close up.
// Stall: when out_tready is low the output holds; the stages behind keep
// filling and in_tready drops only once all four are full. Nothing is lost
// or repeated.
// Reset: synchronous, active low; clears all valid bits, keys and mode to 0.
// ---------------------------------------------------------------------------
module key_colour_alpha_generator
  import kca_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // input pixel words
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [23:0]      in_tdata,   // blue_in, green_in, red_in
  // output pixel words
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,  // blue_out, green_out, red_out, alpha_out
  // configuration writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CH_W-1:0]  cfg_data
);

  localparam int unsigned NSTG = 4;

  // configuration registers
  logic [CH_W-1:0] key_red_r, key_green_r, key_blue_r;
  logic [2:0]      mode_r;

  // pipeline control
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] ld;     // stage k loads this cycle
  grey_en_t        gen;

  // sideband stages 0..2, output register
  side_t           side_r [3];
  side_t           side_in;
  logic [31:0]     out_r;
  logic [CH_W-1:0] pix_grey, key_grey, alpha;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_red_r   <= '0;
      key_green_r <= '0;
      key_blue_r  <= '0;
      mode_r      <= MODE_OPAQUE;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KEY_RED:    key_red_r   <= cfg_data;
        REG_KEY_GREEN:  key_green_r <= cfg_data;
        REG_KEY_BLUE:   key_blue_r  <= cfg_data;
        REG_ALPHA_MODE: mode_r      <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // stage k may load when empty or when its contents move on
  always_comb begin
    ld[NSTG-1] = !vld_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      ld[k] = !vld_r[k] || ld[k+1];
    end
    vld_nxt[0] = ld[0] ? in_tvalid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = ld[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready = ld[0];
  assign gen = '{ld_mul: ld[0], ld_div: ld[1], ld_sum: ld[2]};

  // key match taken at entry, with the mode, so the item keeps its own view
  assign side_in = '{blue:   in_tdata[7:0],
                     green:  in_tdata[15:8],
                     red:    in_tdata[23:16],
                     mode:   mode_r,
                     key_eq: (in_tdata[7:0] == key_blue_r) &&
                             (in_tdata[15:8] == key_green_r) &&
                             (in_tdata[23:16] == key_red_r)};

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      side_r[0] <= side_in;
    end
    if (ld[1]) begin
      side_r[1] <= side_r[0];
    end
    if (ld[2]) begin
      side_r[2] <= side_r[1];
    end
    if (ld[3]) begin
      out_r <= {alpha, side_r[2].red, side_r[2].green, side_r[2].blue};
    end
  end

  kca_grey u_pix_grey (
    .clk   (clk),
    .en    (gen),
    .red   (in_tdata[23:16]),
    .green (in_tdata[15:8]),
    .blue  (in_tdata[7:0]),
    .grey  (pix_grey)
  );

  // key grey runs in step with the pixel so it sees the keys at entry
  kca_grey u_key_grey (
    .clk   (clk),
    .en    (gen),
    .red   (key_red_r),
    .green (key_green_r),
    .blue  (key_blue_r),
    .grey  (key_grey)
  );

  kca_alpha u_alpha (
    .mode     (side_r[2].mode),
    .key_eq   (side_r[2].key_eq),
    .pix_grey (pix_grey),
    .key_grey (key_grey),
    .alpha    (alpha)
  );

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = out_r;

endmodule
